@@ design/lpt_pkg.sv @@
`timescale 1ns / 1ps
package lpt_pkg;

  typedef enum logic [1:0] {
    OP_SAVE    = 2'd0,
    OP_PROTECT = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    OC_UPDATED  = 3'd0,
    OC_APPENDED = 3'd1,
    OC_EVICTED  = 3'd2,
    OC_PINNED   = 3'd3,
    OC_IGNORED  = 3'd4,
    OC_PIN_FULL = 3'd5,
    OC_CLEARED  = 3'd6
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH_RD,
    ST_MATCH_CMP,
    ST_PIN_SCAN,
    ST_EVICT_RD,
    ST_EVICT_PIN,
    ST_EVICT_CMP,
    ST_EVICT_FETCH,
    ST_EVICT_ADDR,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

@@ design/lpt_pin_set.sv @@
`timescale 1ns / 1ps
// pin set: one entry compared per cycle
module lpt_pin_set #(
  parameter int PIN_DEPTH = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        scan_start,
  input  logic [31:0] scan_address,
  input  logic        add_en,
  input  logic [31:0] add_address,
  output logic        scan_busy,
  output logic        scan_hit,
  output logic        full
);
  localparam int IW = (PIN_DEPTH > 1) ? $clog2(PIN_DEPTH) : 1;
  localparam int CW = $clog2(PIN_DEPTH + 1);

  logic [31:0]   pin_mem [PIN_DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic          busy_r;
  logic          hit_r;
  logic [31:0]   key_r;

  assign full      = (count_r == CW'(PIN_DEPTH));
  assign scan_busy = busy_r;
  assign scan_hit  = hit_r;

  // storage
  always_ff @(posedge clk) begin
    if (add_en && !full) begin
      pin_mem[count_r[IW-1:0]] <= add_address;
    end
  end

  // count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (add_en && !full) begin
      count_r <= count_r + CW'(1);
    end
  end

  // sequential compare of the key against every pinned entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hit_r  <= 1'b0;
      idx_r  <= '0;
    end else if (scan_start) begin
      key_r  <= scan_address;
      hit_r  <= 1'b0;
      idx_r  <= '0;
      busy_r <= (count_r != '0);
    end else if (busy_r) begin
      if (pin_mem[idx_r[IW-1:0]] == key_r) begin
        hit_r <= 1'b1;
      end
      if (idx_r + CW'(1) >= count_r) begin
        busy_r <= 1'b0;
      end
      idx_r <= idx_r + CW'(1);
    end
  end
endmodule

@@ design/lru_peer_table_with_pins.sv @@
`timescale 1ns / 1ps
// channel  direction  ports
// in       input      in_valid, in_stall, in_operation, in_peer_address, in_key_word0..3
// out      output     out_valid, out_stall, out_slot, out_outcome, out_evicted_address,
//                     out_use_stamp, out_entry_count
// a save reads the entries one by one in a match pass; when the table is full and nothing
// matched, an evict pass reads each entry, scans the pins for it and keeps the least unpinned stamp;
// a protect scans the pins. the table has one read port; the pin set compares one entry a cycle
// rst_n clears counts, use clock and the sequencer; table contents need none
// in_stall is high while a word is in work or a result waits under out_stall
module lru_peer_table_with_pins #(
  parameter int TABLE_DEPTH = 64,
  parameter int PIN_DEPTH   = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_peer_address,
  input  logic [63:0] in_key_word0,
  input  logic [63:0] in_key_word1,
  input  logic [63:0] in_key_word2,
  input  logic [63:0] in_key_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_slot,
  output logic [2:0]  out_outcome,
  output logic [31:0] out_evicted_address,
  output logic [15:0] out_use_stamp,
  output logic [6:0]  out_entry_count
);
  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = 32 + 256 + 16;

  // table memory: address, key and stamp packed in one word
  logic [EW-1:0] tbl_mem [TABLE_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  lpt_pkg::state_t state_r, state_nxt;
  logic [1:0]    op_r;
  logic [31:0]   addr_r;
  logic [255:0]  key_r;
  logic [CW-1:0] count_r;
  logic [15:0]   clock_r;
  logic [CW-1:0] idx_r;
  logic [SW-1:0] slot_r;
  logic [2:0]    outcome_r;
  logic          found_r;
  logic [15:0]   best_r;
  logic [31:0]   evict_addr_r;
  logic          out_valid_r;
  logic [5:0]    o_slot_r;
  logic [2:0]    o_outcome_r;
  logic [31:0]   o_evicted_r;
  logic [15:0]   o_stamp_r;
  logic [6:0]    o_count_r;

  logic          pin_start;
  logic [31:0]   pin_key;
  logic          pin_add;
  logic          pin_busy;
  logic          pin_hit;
  logic          pin_full;
  logic          accept;
  logic          idx_last;

  assign in_stall = (state_r != lpt_pkg::ST_IDLE) || out_valid_r;
  assign accept   = in_valid && !in_stall;
  assign idx_last = (idx_r + CW'(1) >= count_r);

  lpt_pin_set #(.PIN_DEPTH(PIN_DEPTH)) u_pins (
    .clk(clk), .rst_n(rst_n),
    .scan_start(pin_start), .scan_address(pin_key),
    .add_en(pin_add), .add_address(addr_r),
    .scan_busy(pin_busy), .scan_hit(pin_hit), .full(pin_full)
  );

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  assign rd_addr = (state_r == lpt_pkg::ST_EVICT_FETCH) ? slot_r : idx_r[SW-1:0];
  assign wr_en   = (state_r == lpt_pkg::ST_WRITE);
  assign wr_addr = slot_r;
  assign wr_data = {addr_r, key_r, clock_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            lpt_pkg::OP_SAVE:    state_nxt = (count_r == '0) ? lpt_pkg::ST_WRITE
                                                            : lpt_pkg::ST_MATCH_RD;
            lpt_pkg::OP_PROTECT: state_nxt = lpt_pkg::ST_PIN_SCAN;
            lpt_pkg::OP_CLEAR:   state_nxt = lpt_pkg::ST_DONE;
            default:             state_nxt = lpt_pkg::ST_IDLE;
          endcase
        end
      end
      lpt_pkg::ST_MATCH_RD:  state_nxt = lpt_pkg::ST_MATCH_CMP;
      lpt_pkg::ST_MATCH_CMP: begin
        if (rd_data_r[EW-1 -: 32] == addr_r || rd_data_r[16 +: 256] == key_r) begin
          state_nxt = lpt_pkg::ST_WRITE;
        end else if (!idx_last) begin
          state_nxt = lpt_pkg::ST_MATCH_RD;
        end else if (count_r < CW'(TABLE_DEPTH)) begin
          state_nxt = lpt_pkg::ST_WRITE;
        end else begin
          state_nxt = lpt_pkg::ST_EVICT_RD;
        end
      end
      lpt_pkg::ST_PIN_SCAN:  if (!pin_busy) state_nxt = lpt_pkg::ST_DONE;
      lpt_pkg::ST_EVICT_RD:  state_nxt = lpt_pkg::ST_EVICT_PIN;
      lpt_pkg::ST_EVICT_PIN: state_nxt = lpt_pkg::ST_EVICT_CMP;
      lpt_pkg::ST_EVICT_CMP: begin
        if (!pin_busy) begin
          state_nxt = idx_last ? lpt_pkg::ST_EVICT_FETCH : lpt_pkg::ST_EVICT_RD;
        end
      end
      lpt_pkg::ST_EVICT_FETCH: state_nxt = lpt_pkg::ST_EVICT_ADDR;
      lpt_pkg::ST_EVICT_ADDR:  state_nxt = lpt_pkg::ST_WRITE;
      lpt_pkg::ST_WRITE:       state_nxt = lpt_pkg::ST_DONE;
      lpt_pkg::ST_DONE:        state_nxt = lpt_pkg::ST_IDLE;
      default:                 state_nxt = lpt_pkg::ST_IDLE;
    endcase
  end

  // pin unit control
  always_comb begin
    pin_start = 1'b0;
    pin_key   = addr_r;
    pin_add   = 1'b0;
    unique case (state_r)
      lpt_pkg::ST_IDLE: begin
        pin_start = accept && (in_operation == lpt_pkg::OP_PROTECT);
        pin_key   = in_peer_address;
      end
      lpt_pkg::ST_EVICT_PIN: begin
        pin_start = 1'b1;
        pin_key   = rd_data_r[EW-1 -: 32];
      end
      lpt_pkg::ST_PIN_SCAN: begin
        pin_add = !pin_busy && !pin_hit && (addr_r != '0) && !pin_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_operation == lpt_pkg::OP_SAVE) begin
        clock_r <= clock_r + 16'd1;
      end
      if (accept && in_operation == lpt_pkg::OP_CLEAR) begin
        count_r <= '0;
        clock_r <= '0;
      end
      if (state_r == lpt_pkg::ST_WRITE && outcome_r == lpt_pkg::OC_APPENDED) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == lpt_pkg::ST_DONE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      lpt_pkg::ST_IDLE: begin
        op_r      <= in_operation;
        addr_r    <= in_peer_address;
        key_r     <= {in_key_word3, in_key_word2, in_key_word1, in_key_word0};
        idx_r     <= '0;
        found_r   <= 1'b0;
        best_r    <= '0;
        slot_r    <= count_r[SW-1:0];
        outcome_r <= lpt_pkg::OC_APPENDED;
        evict_addr_r <= '0;
      end
      lpt_pkg::ST_MATCH_CMP: begin
        if (rd_data_r[EW-1 -: 32] == addr_r || rd_data_r[16 +: 256] == key_r) begin
          slot_r    <= idx_r[SW-1:0];
          outcome_r <= lpt_pkg::OC_UPDATED;
        end else if (idx_last) begin
          if (count_r < CW'(TABLE_DEPTH)) begin
            slot_r <= count_r[SW-1:0];
          end else begin
            slot_r    <= '0;
            outcome_r <= lpt_pkg::OC_EVICTED;
            idx_r     <= '0;
          end
        end else begin
          idx_r <= idx_r + CW'(1);
        end
      end
      // protect outcome decided before the pin set takes the address
      lpt_pkg::ST_PIN_SCAN: begin
        if (!pin_busy) begin
          if (pin_hit || addr_r == '0) begin
            outcome_r <= lpt_pkg::OC_IGNORED;
          end else if (pin_full) begin
            outcome_r <= lpt_pkg::OC_PIN_FULL;
          end else begin
            outcome_r <= lpt_pkg::OC_PINNED;
          end
        end
      end
      lpt_pkg::ST_EVICT_CMP: begin
        if (!pin_busy) begin
          if (!pin_hit && (!found_r || rd_data_r[15:0] < best_r)) begin
            best_r  <= rd_data_r[15:0];
            slot_r  <= idx_r[SW-1:0];
            found_r <= 1'b1;
          end
          idx_r <= idx_r + CW'(1);
        end
      end
      lpt_pkg::ST_EVICT_ADDR: evict_addr_r <= rd_data_r[EW-1 -: 32];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == lpt_pkg::ST_DONE) begin
      o_slot_r    <= '0;
      o_evicted_r <= '0;
      o_stamp_r   <= '0;
      o_count_r   <= 7'(count_r);
      unique case (op_r)
        lpt_pkg::OP_SAVE: begin
          o_slot_r    <= 6'(slot_r);
          o_outcome_r <= outcome_r;
          o_evicted_r <= evict_addr_r;
          o_stamp_r   <= clock_r;
        end
        lpt_pkg::OP_PROTECT: o_outcome_r <= outcome_r;
        default: o_outcome_r <= lpt_pkg::OC_CLEARED;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_slot            = o_slot_r;
  assign out_outcome         = o_outcome_r;
  assign out_evicted_address = o_evicted_r;
  assign out_use_stamp       = o_stamp_r;
  assign out_entry_count     = o_count_r;
endmodule
